// ===== design/assert_macros.svh =====
// Shared assertion helpers.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_IMPL(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error("lbl");
`define ASSERT_NEXT(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error("lbl");
`endif

// ===== design/mbeq_pkg.sv =====
package mbeq_pkg;
  localparam logic [1:0] CMD_SAMPLE = 2'd0;
  localparam logic [1:0] CMD_COEF = 2'd1;
  localparam logic [1:0] CMD_GAIN = 2'd2;
  localparam int GAIN_FRAC = 14;
  localparam int GAIN_BITS = 16;
  localparam int IDX_BITS = 9;
  localparam int VAL_BITS = 32;
  localparam int CMD_BITS = 2;
  localparam int PATH_BITS = 1;
  localparam int NUM_K = 5;
endpackage

// ===== design/mbeq_if.sv =====
interface mbeq_in_if #(parameter int SAMPLE_BITS = 24);
  logic valid;
  logic ready;
  logic [mbeq_pkg::CMD_BITS-1:0] cmd;
  logic [mbeq_pkg::PATH_BITS-1:0] path;
  logic signed [SAMPLE_BITS-1:0] sample_in;
  logic [mbeq_pkg::IDX_BITS-1:0] table_index;
  logic signed [mbeq_pkg::VAL_BITS-1:0] table_value;
  modport source (output valid, cmd, path, sample_in, table_index, table_value, input ready);
  modport sink (input valid, cmd, path, sample_in, table_index, table_value, output ready);
endinterface

interface mbeq_out_if #(parameter int SAMPLE_BITS = 24);
  logic valid;
  logic ready;
  logic signed [SAMPLE_BITS-1:0] sample_out;
  logic saturated;
  modport source (output valid, sample_out, saturated, input ready);
  modport sink (input valid, sample_out, saturated, output ready);
endinterface

// ===== design/mbeq_mac.sv =====
module mbeq_mac #(
  parameter int A_BITS = 40,
  parameter int B_BITS = 32,
  parameter int SHIFT = 22
) (
  input  logic                        clk,
  input  logic signed [A_BITS-1:0]    a,
  input  logic signed [B_BITS-1:0]    b,
  output logic signed [A_BITS+B_BITS-SHIFT-1:0] p
);
  logic signed [A_BITS+B_BITS-1:0] prod;
  assign prod = a * b;
  always_ff @(posedge clk) begin
    p <= prod[A_BITS+B_BITS-1:SHIFT];
  end
endmodule

// ===== design/multiband_biquad_equalizer_top.sv =====
// A new sample is accepted only once the previous one is finished and its result registered.
// Table writes are accepted only while idle. One shared multiplier (registered product) sets
// the rate; each filter MAC use steps through the states S_RD, S_M and S_W.
// Reset (rst, synchronous): a clearing pass zeroes delay words and gains; no item is
// accepted meanwhile.
`include "assert_macros.svh"
module multiband_biquad_equalizer_top #(
  parameter int NUM_BANDS = 14,
  parameter int STAGES_PER_BAND = 4,
  parameter int NUM_PATHS = 2,
  parameter int SAMPLE_BITS = 24,
  parameter int COEF_BITS = 32
) (
  input logic clk,
  input logic rst,
  mbeq_in_if.sink in_ch,
  mbeq_out_if.source out_ch
);
  localparam int SIG_BITS = SAMPLE_BITS + 8;
  localparam int DLY_BITS = SAMPLE_BITS + 16;
  localparam int PROD_SHIFT = COEF_BITS - 10;
  localparam int COEF_COUNT = NUM_BANDS * STAGES_PER_BAND * mbeq_pkg::NUM_K;
  localparam int DLY_COUNT = NUM_PATHS * NUM_BANDS * STAGES_PER_BAND;
  localparam int GN_COUNT = NUM_PATHS * NUM_BANDS;
  localparam int CW = $clog2(COEF_COUNT);
  localparam int DW = (DLY_COUNT > 1) ? $clog2(DLY_COUNT) : 1;
  localparam int GW = (GN_COUNT > 1) ? $clog2(GN_COUNT) : 1;
  localparam int BW = (NUM_BANDS > 1) ? $clog2(NUM_BANDS) : 1;
  localparam int SW = (STAGES_PER_BAND > 1) ? $clog2(STAGES_PER_BAND) : 1;
  localparam int PW = (NUM_PATHS > 1) ? $clog2(NUM_PATHS) : 1;
  localparam int MA = SIG_BITS;
  localparam int MB = (COEF_BITS > mbeq_pkg::GAIN_BITS + 1) ? COEF_BITS : mbeq_pkg::GAIN_BITS + 1;
  localparam int MP = MA + MB;
  localparam int ACC_BITS = SIG_BITS + mbeq_pkg::GAIN_BITS + 6;

  localparam logic signed [DLY_BITS+2:0] Y_HI =
    {{(DLY_BITS+4-SIG_BITS){1'b0}}, {(SIG_BITS-1){1'b1}}};
  localparam logic signed [DLY_BITS+2:0] Y_LO = ~Y_HI;
  localparam logic signed [ACC_BITS-1:0] O_HI =
    {{(ACC_BITS-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [ACC_BITS-1:0] O_LO = ~O_HI;

  localparam logic [3:0] S_CLR = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_RD = 4'd2;
  localparam logic [3:0] S_M = 4'd3;
  localparam logic [3:0] S_W = 4'd4;
  localparam logic [3:0] S_GAIN = 4'd5;
  localparam logic [3:0] S_GW = 4'd6;
  localparam logic [3:0] S_FIN = 4'd7;
  localparam logic [3:0] S_OUT = 4'd8;

  logic [3:0] state;
  logic [DW-1:0] clr_cnt;
  logic signed [COEF_BITS-1:0] coef_mem [COEF_COUNT];
  logic signed [DLY_BITS-1:0] d1_mem [DLY_COUNT];
  logic signed [DLY_BITS-1:0] d2_mem [DLY_COUNT];
  logic [mbeq_pkg::GAIN_BITS-1:0] gain_mem [GN_COUNT];
  logic signed [COEF_BITS-1:0] coef_q;
  logic signed [DLY_BITS-1:0] d1_q, d2_q;
  logic [mbeq_pkg::GAIN_BITS-1:0] gain_q;
  logic [PW-1:0] path;
  logic [BW-1:0] band;
  logic [SW-1:0] stage;
  logic [2:0] step;
  logic signed [SIG_BITS-1:0] xin, x, y;
  logic signed [DLY_BITS+2:0] acc1, acc2;
  logic signed [ACC_BITS-1:0] sum;
  logic signed [MA-1:0] ma;
  logic signed [MB-1:0] mb;
  logic signed [MP-1:0] mp;
  logic [CW-1:0] cidx;
  logic [DW-1:0] didx;
  logic [GW-1:0] gidx;
  logic ovalid;
  logic signed [SAMPLE_BITS-1:0] oval;
  logic osat;
  logic do_gain;

  assign cidx = CW'((32'(band) * STAGES_PER_BAND + 32'(stage)) * mbeq_pkg::NUM_K + 32'(step));
  assign didx = DW'((32'(path) * NUM_BANDS + 32'(band)) * STAGES_PER_BAND + 32'(stage));
  assign gidx = GW'(32'(path) * NUM_BANDS + 32'(band));

  function automatic logic signed [DLY_BITS-1:0] sat40(input logic signed [DLY_BITS+2:0] v);
    logic signed [DLY_BITS+2:0] hi, lo;
    hi = (DLY_BITS+3)'({1'b0, {(DLY_BITS-1){1'b1}}});
    lo = ~hi;
    if (v > hi) return hi[DLY_BITS-1:0];
    if (v < lo) return lo[DLY_BITS-1:0];
    return v[DLY_BITS-1:0];
  endfunction

  mbeq_mac #(.A_BITS(MA), .B_BITS(MB), .SHIFT(0)) u_mac (
    .clk(clk), .a(ma), .b(mb), .p(mp));

  always_comb begin
    ma = MA'(x);
    mb = MB'(coef_q);
    if (do_gain) begin
      ma = MA'(y);
      mb = MB'($signed({1'b0, gain_q}));
    end else if (step == 3'd3 || step == 3'd4) begin
      ma = MA'(y);
    end
  end
  assign do_gain = (state == S_GAIN) || (state == S_GW);

  logic signed [DLY_BITS+2:0] mpx, yfull;
  assign mpx = (DLY_BITS+3)'($signed(mp[MP-1:PROD_SHIFT]));
  assign yfull = (mpx + (DLY_BITS+3)'(d1_q)) >>> 8;

  // gain term: product of the shared unit, truncated to ACC_BITS
  logic signed [ACC_BITS-1:0] term;
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready && in_ch.cmd == mbeq_pkg::CMD_COEF
        && 32'(in_ch.path) < NUM_PATHS && 32'(in_ch.table_index) < COEF_COUNT)
      coef_mem[CW'(in_ch.table_index)] <= in_ch.table_value[COEF_BITS-1:0];
    coef_q <= coef_mem[cidx];
    d1_q <= d1_mem[didx];
    d2_q <= d2_mem[didx];
    gain_q <= gain_mem[gidx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      clr_cnt <= '0;
      ovalid <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready && state != S_OUT) ovalid <= 1'b0;
      case (state)
        S_CLR: begin
          d1_mem[clr_cnt] <= '0;
          d2_mem[clr_cnt] <= '0;
          if (32'(clr_cnt) < GN_COUNT) gain_mem[GW'(clr_cnt)] <= '0;
          clr_cnt <= clr_cnt + 1'b1;
          if (32'(clr_cnt) == DLY_COUNT - 1) state <= S_IDLE;
        end
        S_IDLE: begin
          if (in_ch.valid && in_ch.ready && 32'(in_ch.path) < NUM_PATHS) begin
            if (in_ch.cmd == mbeq_pkg::CMD_GAIN && 32'(in_ch.table_index) < NUM_BANDS)
              gain_mem[GW'(32'(in_ch.path) * NUM_BANDS + 32'(in_ch.table_index))] <=
                in_ch.table_value[mbeq_pkg::GAIN_BITS-1:0];
            if (in_ch.cmd == mbeq_pkg::CMD_SAMPLE) begin
              path <= PW'(in_ch.path);
              xin <= SIG_BITS'(in_ch.sample_in);
              x <= SIG_BITS'(in_ch.sample_in);
              band <= '0;
              stage <= '0;
              step <= '0;
              sum <= '0;
              state <= S_RD;
            end
          end
        end
        S_RD: state <= S_M;
        S_M: state <= S_W;
        S_W: begin
          case (step)
            3'd0: begin
              if (yfull > Y_HI) y <= {1'b0, {(SIG_BITS-1){1'b1}}};
              else if (yfull < Y_LO)
                y <= {1'b1, {(SIG_BITS-1){1'b0}}};
              else y <= yfull[SIG_BITS-1:0];
            end
            3'd1: acc1 <= mpx + (DLY_BITS+3)'(d2_q);
            3'd2: acc2 <= mpx;
            3'd3: acc1 <= mpx + acc1;
            default: begin
              d1_mem[didx] <= sat40(acc1);
              d2_mem[didx] <= sat40(mpx + acc2);
            end
          endcase
          state <= S_RD;
          if (step == 3'd4) begin
            step <= '0;
            x <= y;
            if (32'(stage) == STAGES_PER_BAND - 1) begin
              stage <= '0;
              state <= S_GAIN;
            end else stage <= stage + 1'b1;
          end else step <= step + 1'b1;
        end
        S_GAIN: state <= S_GW;
        S_GW: state <= S_FIN;
        S_FIN: begin
          if (band[0]) sum <= sum + term;
          else sum <= sum - term;
          x <= xin;
          if (32'(band) == NUM_BANDS - 1) state <= S_OUT;
          else begin
            band <= band + 1'b1;
            state <= S_RD;
          end
        end
        default: begin
          if (!ovalid || out_ch.ready) begin
            ovalid <= 1'b1;
            osat <= ((sum >>> mbeq_pkg::GAIN_FRAC) > O_HI)
                 || ((sum >>> mbeq_pkg::GAIN_FRAC) < O_LO);
            if ((sum >>> mbeq_pkg::GAIN_FRAC) > O_HI)
              oval <= {1'b0, {(SAMPLE_BITS-1){1'b1}}};
            else if ((sum >>> mbeq_pkg::GAIN_FRAC) < O_LO)
              oval <= {1'b1, {(SAMPLE_BITS-1){1'b0}}};
            else oval <= SAMPLE_BITS'(sum >>> mbeq_pkg::GAIN_FRAC);
            state <= S_IDLE;
          end
        end
      endcase
    end
  end

  assign term = ACC_BITS'(mp);

  assign in_ch.ready = (state == S_IDLE);
  assign out_ch.valid = ovalid;
  assign out_ch.sample_out = oval;
  assign out_ch.saturated = osat;

  `ASSERT_IMPL(a_busy_nrdy, clk, rst, state != S_IDLE, !in_ch.ready)
  `ASSERT_NEXT(a_hold, clk, rst, out_ch.valid && !out_ch.ready, out_ch.valid)
  `ASSERT_IMPL(a_step, clk, rst, state == S_W, step <= 3'd4)
  `ASSERT_NEXT(a_out, clk, rst, state == S_OUT && !out_ch.valid, out_ch.valid)
endmodule
